[hw/rtl/lbsc_pkg.sv]
// Package for the LFSR byte scrambler with block balance check.
// Holds sizes, register indexes, result type and keystream/popcount functions.
// No dependencies.
`timescale 1ns / 1ps

package lbsc_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int MIN_ONES    = 8;
   localparam int MAX_ONES    = (BLOCK_BYTES - 1) * 8;

   localparam int LFSR_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int POP_W   = 4;
   localparam int BCNT_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int ONES_W  = $clog2(BLOCK_BYTES * BYTE_W + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;
   localparam logic [LFSR_W-1:0] KEY_RESET = 32'h0000_0001;

   localparam logic [CSR_IDX_W-1:0] REG_SEED_KEY      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_BALANCE = 2'd1;

   typedef struct packed {
      logic [LFSR_W-1:0] lfsr;
      logic [BYTE_W-1:0] ks;
   } keystep_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              block_done;
      logic              block_unbalanced;
      logic              frame_end;
   } rsp_type;

   // eight Galois steps; bit 31 after each step goes in MSB first
   function automatic keystep_type key_byte(input logic [LFSR_W-1:0] state);
      keystep_type r;
      logic [LFSR_W-1:0] s;
      logic [BYTE_W-1:0] k;
      s = state;
      k = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         s = (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
         k = {k[BYTE_W-2:0], s[LFSR_W-1]};
      end
      r.lfsr = s;
      r.ks   = k;
      return r;
   endfunction

   function automatic logic [POP_W-1:0] pop8(input logic [BYTE_W-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + POP_W'(v[i]);
      end
      return n;
   endfunction

endpackage

[hw/rtl/lfsr_byte_scrambler_balance_check.sv]
// Top level: byte scrambler with 32-bit Galois LFSR keystream and block ones check.
// Depends on lbsc_pkg.
//
//   channel  ports                              direction  handshake
//   req      req_data_byte, req_frame_last      in         req_valid / req_stall
//   rsp      rsp_out_byte, rsp_block_done,      out        rsp_valid / rsp_stall
//            rsp_block_unbalanced, rsp_frame_end
//   csr      csr_index, csr_data                in         csr_valid / csr_ready
//
// One request per cycle while req_stall is low; each result is registered. The keystream
// byte and block counters are computed combinationally from the LFSR and counter
// registers. A two-entry output (result register plus skid register) keeps accepting
// while a result is stalled; req_stall rises only when both are full.
// Synchronous active-high reset loads key 1 and enables the check.
`timescale 1ns / 1ps

module lfsr_byte_scrambler_balance_check
   import lbsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_frame_last,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_block_done,
   output logic                 rsp_block_unbalanced,
   output logic                 rsp_frame_end,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LFSR_W-1:0]    csr_data
);

   logic [LFSR_W-1:0] key_ff, key_in;
   logic              check_ff, check_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [ONES_W-1:0] ones_ff, ones_in;

   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           skid_ff, skid_in;
   logic              skid_valid_ff, skid_valid_in;

   keystep_type       step;
   rsp_type           res;
   logic [ONES_W-1:0] ones_sum;
   logic              accept;
   logic              out_free;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      step     = key_byte(lfsr_ff);
      res.out_byte  = req_data_byte ^ step.ks;
      ones_sum      = ones_ff + ONES_W'(pop8(res.out_byte));
      res.block_done = (bcnt_ff == BCNT_W'(BLOCK_BYTES - 1)) || req_frame_last;
      res.block_unbalanced = res.block_done && check_ff &&
                             ((ones_sum < ONES_W'(MIN_ONES)) ||
                              (ones_sum > ONES_W'(MAX_ONES)));
      res.frame_end = req_frame_last;

      key_in   = key_ff;
      check_in = check_ff;
      lfsr_in  = lfsr_ff;
      bcnt_in  = bcnt_ff;
      ones_in  = ones_ff;

      if (accept) begin
         lfsr_in = req_frame_last ? key_ff : step.lfsr;
         if (res.block_done) begin
            bcnt_in = '0;
            ones_in = '0;
         end else begin
            bcnt_in = bcnt_ff + BCNT_W'(1);
            ones_in = ones_sum;
         end
      end

      if (csr_write) begin
         case (csr_index)
            REG_SEED_KEY: begin
               key_in  = csr_data;
               lfsr_in = csr_data;
            end
            REG_CHECK_BALANCE: begin
               check_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end

      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;

      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= KEY_RESET;
         check_ff      <= 1'b1;
         lfsr_ff       <= KEY_RESET;
         bcnt_ff       <= '0;
         ones_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         key_ff        <= key_in;
         check_ff      <= check_in;
         lfsr_ff       <= lfsr_in;
         bcnt_ff       <= bcnt_in;
         ones_ff       <= ones_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_out_byte         = out_ff.out_byte;
   assign rsp_block_done       = out_ff.block_done;
   assign rsp_block_unbalanced = out_ff.block_unbalanced;
   assign rsp_frame_end        = out_ff.frame_end;

endmodule
